// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the execute unit RTL.
// Each macro takes a label and a property clocked on clk, with rst_n low disabling it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define C65EX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("execute unit assertion failed");

`define C65EX_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("execute unit forbidden condition seen");

`endif

// ===== rtl/core/c65ex_pkg.sv =====
// Package for the 6502 execute unit: word types, operation codes and flag helpers.
// Used by every module under rtl/core; depends on nothing else.
package c65ex_pkg;

    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_B = 4;
    localparam int FLAG_U = 5;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
        OP_STX = 6'd4,  OP_STY = 6'd5,  OP_TAX = 6'd6,  OP_TAY = 6'd7,
        OP_TXA = 6'd8,  OP_TYA = 6'd9,  OP_TSX = 6'd10, OP_TXS = 6'd11,
        OP_PHA = 6'd12, OP_PHP = 6'd13, OP_PLA = 6'd14, OP_PLP = 6'd15,
        OP_AND = 6'd16, OP_EOR = 6'd17, OP_ORA = 6'd18, OP_BIT = 6'd19,
        OP_ADC = 6'd20, OP_SBC = 6'd21, OP_CMP = 6'd22, OP_CPX = 6'd23,
        OP_CPY = 6'd24, OP_INC = 6'd25, OP_INX = 6'd26, OP_INY = 6'd27,
        OP_DEC = 6'd28, OP_DEX = 6'd29, OP_DEY = 6'd30, OP_ASL = 6'd31,
        OP_LSR = 6'd32, OP_ROL = 6'd33, OP_ROR = 6'd34, OP_JMP = 6'd35,
        OP_JSR = 6'd36, OP_RTS = 6'd37, OP_BCC = 6'd38, OP_BCS = 6'd39,
        OP_BEQ = 6'd40, OP_BNE = 6'd41, OP_BMI = 6'd42, OP_BPL = 6'd43,
        OP_BVC = 6'd44, OP_BVS = 6'd45, OP_CLC = 6'd46, OP_CLD = 6'd47,
        OP_CLI = 6'd48, OP_CLV = 6'd49, OP_SEC = 6'd50, OP_SED = 6'd51,
        OP_SEI = 6'd52, OP_BRK = 6'd53, OP_NOP = 6'd54, OP_RTI = 6'd55
    } op_t;

    typedef struct packed {
        logic [5:0]  kind;
        logic [7:0]  operand;
        logic [15:0] target_addr;
        logic        acc_mode;
        logic [15:0] pc_now;
    } in_t;

    typedef struct packed {
        logic        store_valid;
        logic [7:0]  store_data;
        logic [7:0]  acc_out;
        logic [7:0]  x_out;
        logic [7:0]  y_out;
        logic [7:0]  sp_out;
        logic [7:0]  status_out;
        logic        pc_redirect;
        logic [15:0] pc_next;
    } out_t;

    typedef struct packed {
        op_t         kind;
        logic [7:0]  operand;
        logic [15:0] target_addr;
        logic        acc_mode;
        logic [15:0] pc_now;
        logic [15:0] branch_pc;
        logic [15:0] ret_pc;
    } dec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic logic [7:0] set_nz(input logic [7:0] status, input logic [7:0] v);
        logic [7:0] s;
        s = status;
        s[FLAG_N] = v[7];
        s[FLAG_Z] = (v == 8'h00);
        return s;
    endfunction

endpackage

// ===== rtl/core/c65ex_front.sv =====
// Front end of the execute unit: classifies an incoming word and precomputes addresses.
// Depends on c65ex_pkg.
module c65ex_front (
    input  c65ex_pkg::in_t  in_word,
    output c65ex_pkg::dec_t dec_word
);
    import c65ex_pkg::*;

    always_comb
    begin
        dec_word.kind        = op_t'(in_word.kind);
        dec_word.operand     = in_word.operand;
        dec_word.target_addr = in_word.target_addr;
        dec_word.acc_mode    = in_word.acc_mode;
        dec_word.pc_now      = in_word.pc_now;
        dec_word.branch_pc   = in_word.pc_now + {{8{in_word.operand[7]}}, in_word.operand};
        dec_word.ret_pc      = in_word.pc_now + 16'd2;
    end

endmodule

// ===== rtl/core/c65ex_queue.sv =====
// Two-entry queue of decoded words between the front and back ends.
// Depends on c65ex_pkg.
module c65ex_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  c65ex_pkg::dec_t       push_word,
    input  logic                  pop,
    output c65ex_pkg::dec_t       head_word,
    output c65ex_pkg::q_status_t  status
);
    import c65ex_pkg::*;

    dec_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head_word    = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

// ===== rtl/core/c65ex_back.sv =====
// Back end of the execute unit: register file, stack page memory, ALU and result register.
// Depends on c65ex_pkg.
module c65ex_back #(
    parameter int STACK_DEPTH = c65ex_pkg::STACK_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  c65ex_pkg::dec_t  head_word,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output c65ex_pkg::out_t  out_word
);
    import c65ex_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic [7:0] a_reg, a_next;
    logic [7:0] x_reg, x_next;
    logic [7:0] y_reg, y_next;
    logic [7:0] sp_reg, sp_next;
    logic [7:0] p_reg, p_next;
    logic       jsr_phase_reg, jsr_phase_next;
    logic       out_valid_reg, out_valid_next;
    out_t       out_reg;
    out_t       res;

    logic [7:0]    stack_mem [STACK_DEPTH];
    logic [7:0]    rd0_reg, rd1_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr0, raddr1;
    logic [7:0]    wdata;
    logic          exec;

    assign exec = head_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        logic [7:0] sv;
        logic [8:0] sum;
        logic [8:0] diff;
        logic [7:0] cmp_src;
        logic [7:0] add_src;
        logic       take;

        a_next         = a_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        sp_next        = sp_reg;
        p_next         = p_reg;
        jsr_phase_next = jsr_phase_reg;
        pop            = 1'b0;
        we             = 1'b0;
        waddr          = AW'(sp_reg % STACK_DEPTH);
        wdata          = 8'h00;
        take           = 1'b0;
        sv             = 8'h00;
        sum            = 9'd0;
        diff           = 9'd0;
        cmp_src        = a_reg;
        add_src        = head_word.operand;
        res            = '0;
        res.pc_next    = head_word.pc_now;

        if (exec)
        begin
            pop = 1'b1;
            unique case (head_word.kind) inside
                OP_LDA: begin a_next = head_word.operand; p_next = set_nz(p_reg, a_next); end
                OP_LDX: begin x_next = head_word.operand; p_next = set_nz(p_reg, x_next); end
                OP_LDY: begin y_next = head_word.operand; p_next = set_nz(p_reg, y_next); end
                OP_STA: begin res.store_valid = 1'b1; res.store_data = a_reg; end
                OP_STX: begin res.store_valid = 1'b1; res.store_data = x_reg; end
                OP_STY: begin res.store_valid = 1'b1; res.store_data = y_reg; end
                OP_TAX: begin x_next = a_reg; p_next = set_nz(p_reg, a_reg); end
                OP_TAY: begin y_next = a_reg; p_next = set_nz(p_reg, a_reg); end
                OP_TXA: begin a_next = x_reg; p_next = set_nz(p_reg, x_reg); end
                OP_TYA: begin a_next = y_reg; p_next = set_nz(p_reg, y_reg); end
                OP_TSX: begin x_next = sp_reg; p_next = set_nz(p_reg, sp_reg); end
                OP_TXS: sp_next = x_reg;
                OP_PHA, OP_PHP:
                begin
                    we    = 1'b1;
                    wdata = (head_word.kind == OP_PHA) ? a_reg : (p_reg | 8'h30);
                    sp_next = sp_reg - 8'd1;
                end
                OP_PLA:
                begin
                    sp_next = sp_reg + 8'd1;
                    a_next  = rd0_reg;
                    p_next  = set_nz(p_reg, rd0_reg);
                end
                OP_PLP:
                begin
                    sp_next = sp_reg + 8'd1;
                    p_next  = (rd0_reg & 8'hCF) | (p_reg & 8'h30);
                end
                OP_AND: begin a_next = a_reg & head_word.operand; p_next = set_nz(p_reg, a_next); end
                OP_EOR: begin a_next = a_reg ^ head_word.operand; p_next = set_nz(p_reg, a_next); end
                OP_ORA: begin a_next = a_reg | head_word.operand; p_next = set_nz(p_reg, a_next); end
                OP_BIT:
                begin
                    p_next         = (p_reg & 8'h3F) | (head_word.operand & 8'hC0);
                    p_next[FLAG_Z] = ((a_reg & head_word.operand) == 8'h00);
                end
                OP_ADC, OP_SBC:
                begin
                    add_src = (head_word.kind == OP_SBC) ? ~head_word.operand : head_word.operand;
                    sum     = {1'b0, a_reg} + {1'b0, add_src} + {8'h00, p_reg[FLAG_C]};
                    a_next  = sum[7:0];
                    p_next  = set_nz(p_reg, sum[7:0]);
                    p_next[FLAG_C] = sum[8];
                    p_next[FLAG_V] = ~(a_reg[7] ^ add_src[7]) & (a_reg[7] ^ sum[7]);
                end
                OP_CMP, OP_CPX, OP_CPY:
                begin
                    cmp_src = (head_word.kind == OP_CPX) ? x_reg :
                              (head_word.kind == OP_CPY) ? y_reg : a_reg;
                    diff    = {1'b0, cmp_src} - {1'b0, head_word.operand};
                    p_next  = set_nz(p_reg, diff[7:0]);
                    p_next[FLAG_C] = !diff[8];
                end
                OP_INC, OP_DEC:
                begin
                    sv = (head_word.kind == OP_INC) ? head_word.operand + 8'd1
                                                    : head_word.operand - 8'd1;
                    res.store_valid = 1'b1;
                    res.store_data  = sv;
                    p_next = set_nz(p_reg, sv);
                end
                OP_INX: begin x_next = x_reg + 8'd1; p_next = set_nz(p_reg, x_next); end
                OP_INY: begin y_next = y_reg + 8'd1; p_next = set_nz(p_reg, y_next); end
                OP_DEX: begin x_next = x_reg - 8'd1; p_next = set_nz(p_reg, x_next); end
                OP_DEY: begin y_next = y_reg - 8'd1; p_next = set_nz(p_reg, y_next); end
                OP_ASL, OP_LSR, OP_ROL, OP_ROR:
                begin
                    cmp_src = head_word.acc_mode ? a_reg : head_word.operand;
                    if (head_word.kind == OP_ASL || head_word.kind == OP_ROL)
                    begin
                        sv = {cmp_src[6:0],
                              (head_word.kind == OP_ROL) && p_reg[FLAG_C]};
                        p_next[FLAG_C] = cmp_src[7];
                    end
                    else
                    begin
                        sv = {(head_word.kind == OP_ROR) && p_reg[FLAG_C],
                              cmp_src[7:1]};
                        p_next[FLAG_C] = cmp_src[0];
                    end
                    p_next = set_nz(p_next, sv);
                    if (head_word.acc_mode)
                    begin
                        a_next = sv;
                    end
                    else
                    begin
                        res.store_valid = 1'b1;
                        res.store_data  = sv;
                    end
                end
                OP_JMP: begin res.pc_redirect = 1'b1; res.pc_next = head_word.target_addr; end
                OP_JSR:
                begin
                    we      = 1'b1;
                    sp_next = sp_reg - 8'd1;
                    if (!jsr_phase_reg)
                    begin
                        wdata          = head_word.ret_pc[15:8];
                        pop            = 1'b0;
                        jsr_phase_next = 1'b1;
                    end
                    else
                    begin
                        wdata           = head_word.ret_pc[7:0];
                        jsr_phase_next  = 1'b0;
                        res.pc_redirect = 1'b1;
                        res.pc_next     = head_word.target_addr;
                    end
                end
                OP_RTS:
                begin
                    sp_next         = sp_reg + 8'd2;
                    res.pc_redirect = 1'b1;
                    res.pc_next     = {rd1_reg, rd0_reg} + 16'd1;
                end
                OP_BCC: take = !p_reg[FLAG_C];
                OP_BCS: take = p_reg[FLAG_C];
                OP_BEQ: take = p_reg[FLAG_Z];
                OP_BNE: take = !p_reg[FLAG_Z];
                OP_BMI: take = p_reg[FLAG_N];
                OP_BPL: take = !p_reg[FLAG_N];
                OP_BVC: take = !p_reg[FLAG_V];
                OP_BVS: take = p_reg[FLAG_V];
                OP_CLC: p_next[FLAG_C] = 1'b0;
                OP_CLD: p_next[FLAG_D] = 1'b0;
                OP_CLI: p_next[FLAG_I] = 1'b0;
                OP_CLV: p_next[FLAG_V] = 1'b0;
                OP_SEC: p_next[FLAG_C] = 1'b1;
                OP_SED: p_next[FLAG_D] = 1'b1;
                OP_SEI: p_next[FLAG_I] = 1'b1;
                default: ;
            endcase
            if (take)
            begin
                res.pc_redirect = 1'b1;
                res.pc_next     = head_word.branch_pc;
            end
        end

        res.acc_out    = a_next;
        res.x_out      = x_next;
        res.y_out      = y_next;
        res.sp_out     = sp_next;
        res.status_out = p_next;

        raddr0 = AW'(8'(sp_next + 8'd1) % STACK_DEPTH);
        raddr1 = AW'(8'(sp_next + 8'd2) % STACK_DEPTH);

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg         <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            sp_reg        <= SP_RESET;
            p_reg         <= STATUS_RESET;
            jsr_phase_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            a_reg         <= a_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            sp_reg        <= sp_next;
            p_reg         <= p_next;
            jsr_phase_reg <= jsr_phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= res;
        end
    end

    // The two read ports always look one and two entries above the next stack pointer,
    // with the write of this cycle forwarded.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            stack_mem[waddr] <= wdata;
        end
        rd0_reg <= (we && waddr == raddr0) ? wdata : stack_mem[raddr0];
        rd1_reg <= (we && waddr == raddr1) ? wdata : stack_mem[raddr1];
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

// ===== rtl/core/cpu6502_execute_unit.sv =====
// Execute unit of a 6502-style processor: top level joining front end, queue and back end.
// Depends on c65ex_pkg, c65ex_front, c65ex_queue, c65ex_back and assert_macros.svh.
//
// Each input word carries one decoded operation with its operand, target address,
// accumulator-mode bit and current PC. Each output word carries the store request,
// the registers A, X, Y, SP and status after the operation, and the next PC.
// Both channels use valid and stall; a word moves on a clock edge with valid high
// and stall low. Exactly one output word is produced for every input word, in order.
// An accepted input word is registered in the queue and its result in the output register.
// While the result side is not stalled, throughput is one word per cycle for all operations
// except JSR, which holds the queue head until it has pushed both bytes, because the
// stack page memory has one write port. A two-entry queue separates the front and back ends.
// Reset clears A, X, Y, sets SP to FD and status to 24, empties the queue and drops
// any pending output word; the stack page is not cleared. While the receiver stalls,
// the output word holds, and input words are still taken until the queue is full.
module cpu6502_execute_unit #(
    parameter int STACK_DEPTH = c65ex_pkg::STACK_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  c65ex_pkg::in_t   in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output c65ex_pkg::out_t  out_word
);
    import c65ex_pkg::*;

    `include "assert_macros.svh"

    dec_t      dec_word;
    dec_t      head_word;
    q_status_t q_stat;
    logic      q_push;
    logic      q_pop;

    assign in_stall = q_stat.full;
    assign q_push   = in_valid && !q_stat.full;

    c65ex_front u_front (
        .in_word  (in_word),
        .dec_word (dec_word)
    );

    c65ex_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (dec_word),
        .pop       (q_pop),
        .head_word (head_word),
        .status    (q_stat)
    );

    c65ex_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (!q_stat.empty),
        .head_word  (head_word),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

    `C65EX_NEVER(a_queue_full_and_empty, q_stat.full && q_stat.empty)
    `C65EX_ASSERT(a_pop_needs_word, q_pop |-> !q_stat.empty)
    `C65EX_ASSERT(a_push_fills_queue, q_push |=> !q_stat.empty)
    `C65EX_ASSERT(a_pop_gives_output, q_pop |=> out_valid)

endmodule
